// ----- src/hse_pkg.sv -----
package hse_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int WORD_W = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD_INIT,
    ST_BUILD_X,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_SORT_INIT,
    ST_SORT_SWAP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } hse_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_BUILD_FETCH,
    OP_TAKE_X,
    OP_SIFT_READ,
    OP_SIFT_STEP,
    OP_SORT_SETUP,
    OP_SORT_FETCH,
    OP_SORT_SWAP,
    OP_EMIT_SETUP,
    OP_EMIT_READ,
    OP_EMIT_LOAD,
    OP_EMIT_NEXT
  } hse_op_t;

  typedef struct packed {
    hse_op_t op;
  } hse_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_le1;
    logic sift_more;
    logic final_word;
  } hse_status_t;

endpackage

// ----- src/hse_ram.sv -----
module hse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/hse_datapath.sv -----
module hse_datapath #(
  parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hse_pkg::hse_cmd_t                cmd,
  output hse_pkg::hse_status_t             status,
  input  logic signed [hse_pkg::WORD_W-1:0] value,
  input  logic                             last,
  output logic signed [hse_pkg::WORD_W-1:0] sorted_value,
  output logic                             final_res,
  output logic                             overflowed
);
  import hse_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;

  logic [CW-1:0] count, count_next;
  logic          drop, drop_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] size, size_next;
  logic [AW-1:0] node, node_next;
  logic signed [WORD_W-1:0] x, x_next;

  logic [CW-1:0] km1;
  logic [CW-1:0] cnt_inc;
  logic [XW-1:0] lc, rc;
  logic          lc_ok, rc_ok, pick_r;
  logic [XW-1:0] child;
  logic signed [WORD_W-1:0] cv;
  logic signed [WORD_W-1:0] rd_a, rd_b;
  logic          full;

  logic              we;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [WORD_W-1:0] wdata;

  assign km1     = k - CW'(1);
  assign cnt_inc = count + CW'(1);
  assign full    = (count >= CW'(DEPTH));
  assign lc      = {1'b0, node, 1'b1};
  assign rc      = lc + XW'(1);
  assign lc_ok   = lc < XW'(size);
  assign rc_ok   = rc < XW'(size);
  assign pick_r  = rc_ok && (rd_b > rd_a);
  assign child   = pick_r ? rc : lc;
  assign cv      = pick_r ? rd_b : rd_a;

  assign status.k_zero     = (k == '0);
  assign status.k_le1      = (k <= CW'(1));
  assign status.sift_more  = lc_ok && (cv > x);
  assign status.final_word = final_res;

  always_comb begin
    we      = 1'b0;
    waddr   = node;
    wdata   = x;
    raddr_a = lc[AW-1:0];
    raddr_b = rc[AW-1:0];
    unique case (cmd.op)
      OP_STORE: begin
        we    = !full;
        waddr = count[AW-1:0];
        wdata = value;
      end
      OP_SIFT_STEP: begin
        we    = 1'b1;
        waddr = node;
        wdata = status.sift_more ? cv : x;
      end
      OP_SORT_SWAP: begin
        we    = 1'b1;
        waddr = km1[AW-1:0];
        wdata = rd_a;
      end
      OP_BUILD_FETCH: raddr_a = km1[AW-1:0];
      OP_SORT_FETCH: begin
        raddr_a = '0;
        raddr_b = km1[AW-1:0];
      end
      OP_EMIT_READ: raddr_a = k[AW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    count_next = count;
    drop_next  = drop;
    k_next     = k;
    size_next  = size;
    node_next  = node;
    x_next     = x;
    unique case (cmd.op)
      OP_STORE: begin
        if (full) begin
          drop_next = 1'b1;
        end else begin
          count_next = cnt_inc;
        end
        if (last) begin
          k_next    = count_next >> 1;
          size_next = count_next;
        end
      end
      OP_BUILD_FETCH: begin
        k_next    = km1;
        node_next = km1[AW-1:0];
      end
      OP_TAKE_X: x_next = rd_a;
      OP_SIFT_STEP: begin
        if (status.sift_more) begin
          node_next = child[AW-1:0];
        end
      end
      OP_SORT_SETUP: k_next = count;
      OP_SORT_SWAP: begin
        x_next    = rd_b;
        node_next = '0;
        size_next = km1;
        k_next    = km1;
      end
      OP_EMIT_SETUP: k_next = '0;
      OP_EMIT_NEXT: begin
        if (final_res) begin
          count_next = '0;
          drop_next  = 1'b0;
        end else begin
          k_next = k + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else begin
      count <= count_next;
      drop  <= drop_next;
    end
  end

  always_ff @(posedge clk) begin
    k    <= k_next;
    size <= size_next;
    node <= node_next;
    x    <= x_next;
    if (cmd.op == OP_EMIT_LOAD) begin
      sorted_value <= rd_a;
      final_res    <= (k == count - CW'(1));
      overflowed   <= drop;
    end
  end

  hse_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

endmodule

// ----- src/hse_ctrl.sv -----
module hse_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  hse_pkg::hse_status_t status,
  output hse_pkg::hse_cmd_t    cmd
);
  import hse_pkg::*;

  hse_state_t state, state_next;
  logic       sorting, sorting_next;

  always_comb begin
    state_next   = state;
    sorting_next = sorting;
    unique case (state)
      ST_LOAD: begin
        sorting_next = 1'b0;
        if (in_valid && last) begin
          state_next = ST_BUILD_INIT;
        end
      end
      ST_BUILD_INIT: begin
        if (status.k_zero) begin
          sorting_next = 1'b1;
          state_next   = ST_SORT_INIT;
        end else begin
          state_next = ST_BUILD_X;
        end
      end
      ST_BUILD_X: state_next = ST_SIFT_RD;
      ST_SIFT_RD: state_next = ST_SIFT_CMP;
      ST_SIFT_CMP: begin
        priority if (status.sift_more) begin
          state_next = ST_SIFT_RD;
        end else if (sorting) begin
          state_next = ST_SORT_INIT;
        end else begin
          state_next = ST_BUILD_INIT;
        end
      end
      ST_SORT_INIT: state_next = status.k_le1 ? ST_EMIT_RD : ST_SORT_SWAP;
      ST_SORT_SWAP: state_next = ST_SIFT_RD;
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: state_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_ready) begin
          state_next = status.final_word ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_STORE;
        end
      end
      ST_BUILD_INIT: cmd.op = status.k_zero ? OP_SORT_SETUP : OP_BUILD_FETCH;
      ST_BUILD_X:    cmd.op = OP_TAKE_X;
      ST_SIFT_RD:    cmd.op = OP_SIFT_READ;
      ST_SIFT_CMP:   cmd.op = OP_SIFT_STEP;
      ST_SORT_INIT:  cmd.op = status.k_le1 ? OP_EMIT_SETUP : OP_SORT_FETCH;
      ST_SORT_SWAP:  cmd.op = OP_SORT_SWAP;
      ST_EMIT_RD:    cmd.op = OP_EMIT_READ;
      ST_EMIT_LD:    cmd.op = OP_EMIT_LOAD;
      ST_EMIT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.op = OP_EMIT_NEXT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      sorting <= 1'b0;
    end else begin
      state   <= state_next;
      sorting <= sorting_next;
    end
  end

endmodule

// ----- src/heap_sort_engine.sv -----
// loading takes one word per cycle; after the last word the heap build visits each of the
// count/2 inner nodes (fetch the node, take its value, then sift it down) and extraction
// repeatedly swaps the root with the last heap word and sifts again, one sift level
// being a two-port ram read then a compare and write
// results are read, loaded and held until out_ready; input reopens after the final word
// reset: synchronous, clears the sequencer, word count and drop flag; the ram is not cleared
module heap_sort_engine #(
  parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [hse_pkg::WORD_W-1:0] value,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hse_pkg::WORD_W-1:0] sorted_value,
  output logic                              final_res,
  output logic                              overflowed
);
  import hse_pkg::*;

  hse_cmd_t    cmd;
  hse_status_t status;

  hse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last      (last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hse_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .last         (last),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .overflowed   (overflowed)
  );

endmodule

// ----- src/hse_checker.sv -----
module hse_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic signed [hse_pkg::WORD_W-1:0] value,
  input logic                              last,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [hse_pkg::WORD_W-1:0] sorted_value,
  input logic                              final_res,
  input logic                              overflowed
);

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output active together");

  // last word starts the sort
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last) |=> !in_ready)
    else $error("input still open after last word");

  // final word taken returns to loading
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && final_res) |=> (in_ready && !out_valid))
    else $error("no return to load after final word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(sorted_value) && $stable(final_res) && $stable(overflowed)))
    else $error("stalled output word changed");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (.*);
